/* rtl/sgb_pkg.sv */
// Shared constants, types and helper functions of the separable Gaussian blur.
`default_nettype none
package sgb_pkg;

  localparam int RADIUS     = 3;
  localparam int TAPS       = 2 * RADIUS + 1;
  localparam int ROWS       = 2 * RADIUS;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int POS_W      = 11;
  localparam int HROW_W     = 12;
  localparam int DIM_W      = 12;
  localparam int Q_W        = 23;
  localparam int COEF_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 27;
  localparam int SLOT_W     = 3;
  localparam int COL_AW     = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = SLOT_W + COL_AW;
  localparam int MEM_DEPTH  = ROWS * MAX_WIDTH;
  localparam int TAP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int B_SHIFT = 0;
  localparam int G_SHIFT = 1;
  localparam int R_SHIFT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 3'd0,
    CFG_WIDTH       = 3'd1,
    CFG_HEIGHT      = 3'd2,
    CFG_COEF_CENTER = 3'd3,
    CFG_COEF_ONE    = 3'd4,
    CFG_COEF_TWO    = 3'd5,
    CFG_COEF_THREE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRAME,
    S_TOTAL,
    S_CHECK,
    S_PASS,
    S_HORZ,
    S_HFIN,
    S_HWR,
    S_VRD,
    S_VACC,
    S_VFIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic latch_frame;
    logic calc_total;
    logic step_in;
    logic h_tap;
    logic h_finish;
    logic v_read;
    logic v_tap;
    logic v_finish;
    logic mem_write;
    logic emit_pass;
    logic emit_blur;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic cmd;
    logic q_zero;
    logic act_en;
    logic draining;
    logic q_lt_r;
    logic hr_lt_r;
    logic tap_pen;
    logic tap_last;
    logic out_busy;
  } dp_status_t;

  // Coefficient slot for a tap position 0..TAPS-1 (distance from center).
  function automatic logic [1:0] tap_coef(input logic [TAP_W-1:0] k);
    logic [TAP_W-1:0] d;
    d = (k >= TAP_W'(RADIUS)) ? k - TAP_W'(RADIUS) : TAP_W'(RADIUS) - k;
    return d[1:0];
  endfunction

  // Drop the fraction bits and clamp to the 8-bit range.
  function automatic logic [CH_W-1:0] finish(input logic [ACC_W-1:0] s);
    logic [ACC_W-FRAC_W-1:0] ip;
    ip = s[ACC_W-1:FRAC_W];
    return (ip > (ACC_W-FRAC_W)'(255)) ? 8'hFF : ip[CH_W-1:0];
  endfunction

  // Wrap a slot sum below 2*ROWS into 0..ROWS-1.
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] s);
    logic [SLOT_W:0] r;
    r = (s >= (SLOT_W+1)'(ROWS)) ? s - (SLOT_W+1)'(ROWS) : s;
    return r[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/sgb_in_if.sv */
// Input pixel channel: valid/ready beat carrying a command and a BGRA pixel.
`default_nettype none
interface sgb_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;
  logic [7:0] in_alpha;

  modport source (output valid, command, in_blue, in_green, in_red, in_alpha, input ready);
  modport sink   (input valid, command, in_blue, in_green, in_red, in_alpha, output ready);
endinterface
`default_nettype wire

/* rtl/sgb_out_if.sv */
// Result channel: valid/ready beat carrying a blurred pixel and its position.
`default_nettype none
interface sgb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [7:0]  out_alpha;
  logic [10:0] out_row;
  logic [10:0] out_col;
  logic        frame_done;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, out_row, out_col,
                  frame_done, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, out_row, out_col,
                  frame_done, output ready);
endinterface
`default_nettype wire

/* rtl/sgb_ctrl.sv */
// Sequencing state machine of the blur: steps one beat through its passes.
`default_nettype none
module sgb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgb_pkg::dp_status_t status_i,
  output sgb_pkg::ctrl_cmd_t  cmd_o
);
  import sgb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = 1'b1;
        if (status_i.in_valid) state_d = S_FRAME;
      end
      S_FRAME: begin
        if (status_i.q_zero) begin
          if (status_i.cmd) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.latch_frame = 1'b1;
            state_d = S_TOTAL;
          end
        end else begin
          state_d = S_CHECK;
        end
      end
      S_TOTAL: begin
        cmd_o.calc_total = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!status_i.act_en) begin
          state_d = status_i.cmd ? S_IDLE : S_PASS;
        end else if (!status_i.draining && status_i.cmd) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.step_in = 1'b1;
          state_d = status_i.q_lt_r ? S_IDLE : S_HORZ;
        end
      end
      S_PASS: begin
        if (!status_i.out_busy) begin
          cmd_o.emit_pass = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_HORZ: begin
        cmd_o.h_tap = 1'b1;
        if (status_i.tap_last) state_d = S_HFIN;
      end
      S_HFIN: begin
        cmd_o.h_finish = 1'b1;
        state_d = status_i.hr_lt_r ? S_HWR : S_VRD;
      end
      S_HWR: begin
        cmd_o.mem_write = 1'b1;
        state_d = S_IDLE;
      end
      S_VRD: begin
        cmd_o.v_read = 1'b1;
        state_d = S_VACC;
      end
      S_VACC: begin
        cmd_o.v_tap = 1'b1;
        if (status_i.tap_last)     state_d = S_VFIN;
        else if (status_i.tap_pen) state_d = S_VACC;
        else                       state_d = S_VRD;
      end
      S_VFIN: begin
        cmd_o.v_finish  = 1'b1;
        cmd_o.mem_write = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit_blur = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/sgb_datapath.sv */
// Datapath of the blur: registers, counters, tap window, line store and MACs.
`default_nettype none
module sgb_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  sgb_in_if.sink                           in_ch,
  sgb_out_if.source                        out_ch,
  input  sgb_pkg::ctrl_cmd_t               cmd_i,
  output sgb_pkg::dp_status_t              status_o
);
  import sgb_pkg::*;

  // configuration
  logic                en_q;
  logic [DIM_W-1:0]    w_q, h_q;
  logic [COEF_W-1:0]   coef_q [4];

  // frame state
  logic                act_en_q;
  logic [DIM_W-1:0]    act_w_q, act_h_q;
  logic [Q_W-1:0]      total_q, q_q;
  logic [POS_W-1:0]    in_row_q, in_col_q;
  logic [POS_W-1:0]    hc_q;
  logic [HROW_W-1:0]   hr_q;
  logic [SLOT_W-1:0]   slot_q;

  // item and arithmetic
  logic                cmd_q;
  logic [PIX_W-1:0]    px_q;
  logic [PIX_W-1:0]    win_q [TAPS];
  logic [TAP_W-1:0]    k_q;
  logic [ACC_W-1:0]    acc_q [3];
  logic [PIX_W-1:0]    hv_q, ov_q, rd_q, res_q;

  logic [PIX_W-1:0]    line_mem [MEM_DEPTH];

  logic                out_v_q;
  logic [PIX_W-1:0]    out_px_q;
  logic [POS_W-1:0]    out_row_q, out_col_q;
  logic                out_done_q;

  logic [HROW_W-1:0]   vr;
  logic                horz_ok, vert_ok, blur_done, pass_done, out_busy;
  logic [COEF_W-1:0]   tap_w;
  logic [PIX_W-1:0]    tap_px;
  logic [DIM_W-1:0]    w_clamp, h_clamp;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [SLOT_W-1:0]   rd_slot;

  assign vr       = hr_q - HROW_W'(RADIUS);
  assign horz_ok  = ({1'b0, hc_q} >= (POS_W+1)'(RADIUS)) &&
                    ((DIM_W+1)'(hc_q) + (DIM_W+1)'(RADIUS) < (DIM_W+1)'(act_w_q));
  assign vert_ok  = (vr >= HROW_W'(RADIUS)) &&
                    ((HROW_W+1)'(vr) + (HROW_W+1)'(RADIUS) < (HROW_W+1)'(act_h_q));
  assign blur_done = (vr == act_h_q - DIM_W'(1)) && (DIM_W'(hc_q) == act_w_q - DIM_W'(1));
  assign pass_done = (q_q == total_q - Q_W'(1));
  assign out_busy  = out_v_q && !out_ch.ready;

  assign w_clamp = (w_q == '0) ? DIM_W'(1) :
                   (w_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_q;
  assign h_clamp = (h_q == '0) ? DIM_W'(1) :
                   (h_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_q;

  assign tap_w   = coef_q[tap_coef(k_q)];
  assign tap_px  = cmd_i.v_tap ? ((k_q == TAP_W'(TAPS-1)) ? hv_q : rd_q) : win_q[k_q];
  assign rd_slot = slot_wrap({1'b0, slot_q} + (SLOT_W+1)'(k_q));
  assign rd_addr = {rd_slot, hc_q[COL_AW-1:0]};
  assign wr_addr = {slot_q, hc_q[COL_AW-1:0]};

  assign in_ch.ready = cmd_i.capture;

  assign status_o.in_valid = in_ch.valid;
  assign status_o.cmd      = cmd_q;
  assign status_o.q_zero   = (q_q == '0);
  assign status_o.act_en   = act_en_q;
  assign status_o.draining = (q_q >= total_q);
  assign status_o.q_lt_r   = (q_q < Q_W'(RADIUS));
  assign status_o.hr_lt_r  = (hr_q < HROW_W'(RADIUS));
  assign status_o.tap_pen  = (k_q == TAP_W'(TAPS-2));
  assign status_o.tap_last = (k_q == TAP_W'(TAPS-1));
  assign status_o.out_busy = out_busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b0;
      w_q       <= DIM_W'(640);
      h_q       <= DIM_W'(480);
      coef_q[0] <= COEF_W'(26145);
      coef_q[1] <= COEF_W'(15858);
      coef_q[2] <= COEF_W'(3538);
      coef_q[3] <= COEF_W'(290);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:      en_q      <= cfg_data_i[0];
        CFG_WIDTH:       w_q       <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:      h_q       <= cfg_data_i[DIM_W-1:0];
        CFG_COEF_CENTER: coef_q[0] <= cfg_data_i;
        CFG_COEF_ONE:    coef_q[1] <= cfg_data_i;
        CFG_COEF_TWO:    coef_q[2] <= cfg_data_i;
        CFG_COEF_THREE:  coef_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_en_q <= 1'b0;
      act_w_q  <= DIM_W'(640);
      act_h_q  <= DIM_W'(480);
      total_q  <= Q_W'(640 * 480);
      q_q      <= '0;
      in_row_q <= '0;
      in_col_q <= '0;
      hc_q     <= '0;
      hr_q     <= '0;
      slot_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.latch_frame) begin
        act_en_q <= en_q;
        act_w_q  <= w_clamp;
        act_h_q  <= h_clamp;
      end
      if (cmd_i.calc_total) begin
        total_q <= Q_W'(act_w_q) * Q_W'(act_h_q);
      end
      // end of frame: return all positions to zero
      if ((cmd_i.emit_blur && blur_done) || (cmd_i.emit_pass && pass_done)) begin
        q_q      <= '0;
        in_row_q <= '0;
        in_col_q <= '0;
        hc_q     <= '0;
        hr_q     <= '0;
        slot_q   <= '0;
      end else begin
        if (cmd_i.step_in || cmd_i.emit_pass) begin
          q_q <= q_q + Q_W'(1);
          if (DIM_W'(in_col_q) + DIM_W'(1) >= act_w_q) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + POS_W'(1);
          end else begin
            in_col_q <= in_col_q + POS_W'(1);
          end
        end
        // advance the horizontal-output position once its line entry is written
        if ((cmd_i.mem_write && !cmd_i.v_finish) || cmd_i.emit_blur) begin
          if (DIM_W'(hc_q) + DIM_W'(1) >= act_w_q) begin
            hc_q   <= '0;
            hr_q   <= hr_q + HROW_W'(1);
            slot_q <= slot_wrap({1'b0, slot_q} + (SLOT_W+1)'(1));
          end else begin
            hc_q <= hc_q + POS_W'(1);
          end
        end
      end
      if (cmd_i.emit_pass || cmd_i.emit_blur) begin
        out_v_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers and arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_ch.valid) begin
      cmd_q <= in_ch.command;
      px_q  <= {in_ch.in_alpha, in_ch.in_red, in_ch.in_green, in_ch.in_blue};
    end
    if (cmd_i.step_in) begin
      for (int i = 0; i < TAPS - 1; i++) win_q[i] <= win_q[i+1];
      win_q[TAPS-1] <= (q_q >= total_q) ? '0 : px_q;
    end
    if (cmd_i.step_in || cmd_i.h_finish) begin
      k_q <= '0;
      for (int c = 0; c < 3; c++) acc_q[c] <= '0;
    end
    if (cmd_i.h_tap || cmd_i.v_tap) begin
      k_q <= k_q + TAP_W'(1);
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_q[c] + ACC_W'(tap_w) * ACC_W'(tap_px[CH_W*c +: CH_W]);
      end
    end
    if (cmd_i.v_tap && k_q == TAP_W'(RADIUS)) begin
      ov_q <= rd_q;
    end
    if (cmd_i.h_finish) begin
      hv_q <= horz_ok ? {win_q[RADIUS][31:24], finish(acc_q[R_SHIFT]),
                         finish(acc_q[G_SHIFT]), finish(acc_q[B_SHIFT])}
                      : win_q[RADIUS];
    end
    if (cmd_i.v_finish) begin
      res_q <= vert_ok ? {ov_q[31:24], finish(acc_q[R_SHIFT]),
                          finish(acc_q[G_SHIFT]), finish(acc_q[B_SHIFT])}
                       : ov_q;
    end
    if (cmd_i.v_read) begin
      rd_q <= line_mem[rd_addr];
    end
    if (cmd_i.mem_write) begin
      line_mem[wr_addr] <= hv_q;
    end
    if (cmd_i.emit_pass) begin
      out_px_q   <= px_q;
      out_row_q  <= in_row_q;
      out_col_q  <= in_col_q;
      out_done_q <= pass_done;
    end
    if (cmd_i.emit_blur) begin
      out_px_q   <= res_q;
      out_row_q  <= vr[POS_W-1:0];
      out_col_q  <= hc_q;
      out_done_q <= blur_done;
    end
  end

  assign out_ch.valid      = out_v_q;
  assign out_ch.out_blue   = out_px_q[7:0];
  assign out_ch.out_green  = out_px_q[15:8];
  assign out_ch.out_red    = out_px_q[23:16];
  assign out_ch.out_alpha  = out_px_q[31:24];
  assign out_ch.out_row    = out_row_q;
  assign out_ch.out_col    = out_col_q;
  assign out_ch.frame_done = out_done_q;

endmodule
`default_nettype wire

/* rtl/separable_gaussian_blur_rgb_unit.sv */
// Top level of the 7-tap separable Gaussian blur on a BGRA pixel stream.
`default_nettype none
// Usage:
//   in_ch_i carries one beat per pixel (command 0) or flush tick (command 1)
//   in raster order; out_ch_o carries blurred pixels with row, column and a
//   frame_done flag on the last pixel. Registers are written through the
//   cfg port while the block is idle; enable, width and height are taken at
//   the first pixel of a frame, coefficients act at once.
//   Sequencing: one beat at a time. A pixel that yields a result runs 7
//   horizontal MAC steps, 6 line-store reads each with a MAC step, one
//   MAC step for the current row, then the output load; the first pixel
//   of a frame also computes the frame total. Beats without a result end
//   at the window shift or after the line-store write, pass-through beats
//   (enable low) after the output load. The single line-store read port
//   and the one shared set of three channel multipliers serialise these steps.
//   Results trail the input by RADIUS rows plus RADIUS pixels; send flush
//   ticks after the last pixel to drain them.
//   Reset clears the frame counters and the output valid; the line store
//   is not cleared, as no entry unwritten in the frame reaches an output.
//   A stalled receiver holds the output register; the block still accepts
//   the next beat and works it up to the output stage, then waits.
module separable_gaussian_blur_rgb_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sgb_in_if.sink                         in_ch_i,
  sgb_out_if.source                      out_ch_o
);
  import sgb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: one state per pass step
  sgb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // datapath: config, counters, window, line store, MACs, output register
  sgb_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch_i),
    .out_ch     (out_ch_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule
`default_nettype wire
